// ----- rtl/lcw_pkg.sv -----
// Shared types and constants for the Format80 (LCW) decompressor.
package lcw_pkg;

    localparam int unsigned OUT_SIZE = 65536;
    localparam int unsigned HIST_AW  = 16;
    localparam int unsigned POS_W    = 17;
    localparam int unsigned Q_DEPTH  = 4;
    localparam int unsigned Q_AW     = 2;

    localparam logic [POS_W-1:0] OUT_SIZE_POS = POS_W'(OUT_SIZE);

    localparam logic [7:0] OP_TOP     = 8'h80;
    localparam logic [7:0] OP_CMASK   = 8'h3f;
    localparam logic [7:0] OP_LIT     = 8'h40;
    localparam logic [5:0] OP_FILL    = 6'h3e;
    localparam logic [7:0] OP_RELHI   = 8'h0f;

    localparam logic [2:0] ST_ABSORBED = 3'd0;
    localparam logic [2:0] ST_BYTE     = 3'd1;
    localparam logic [2:0] ST_END      = 3'd2;
    localparam logic [2:0] ST_WRONG    = 3'd3;
    localparam logic [2:0] ST_BAD      = 3'd4;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       out_byte;
        logic [POS_W-1:0] out_position;
        logic             expanding;
    } t_out_rsp;

    // One classified request handed from the front to the back.
    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         byte_val;
        logic [POS_W-1:0]   pos;
        logic               expanding;
        logic               is_copy;
        logic               wr;
        logic [HIST_AW-1:0] rd_addr;
    } t_job;

endpackage

// ----- rtl/lcw_format80_decompressor.sv -----
// Format80 (LCW) decompressor top level.
// Path: a request is written into the queue, then loaded into the back stage with the
//   history read, then into the output register; a stalled output holds it in place.
// Throughput: one request per cycle while the output does not stall; the 64K x 8
//   history has one write and one registered read port, and a copy of the byte
//   written just before is forwarded.
// Reset: synchronous active-low i_rst_n clears parser state, queue and valids;
//   history contents are not cleared and need no clearing pass.
module lcw_format80_decompressor
    import lcw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_rsp o_out_rsp
);

    logic q_full;
    logic q_valid;
    logic q_pop;
    logic accept;
    t_job f_job;
    t_job q_job;

    // Stall only when the queue has no room; the back drains it on its own.
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    // Front: parses the compressed stream and resolves each request fully,
    // except the history read needed by a copy.
    lcw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_req),
        .o_job    (f_job)
    );

    lcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // Back: history memory access, byte writes, result register.
    lcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_pop       (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

    // Only a byte-out result carries a nonzero byte.
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.status != ST_BYTE) |-> (o_out_rsp.out_byte == 8'h00))
        else $error("nonzero byte on non-byte result");

    // End of image never leaves an expansion pending.
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.status == ST_END) |-> !o_out_rsp.expanding)
        else $error("expanding set at end of image");

    // The back never pops an empty queue.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

// ----- rtl/lcw_front.sv -----
// Front: command parser and decoder state, one request per cycle while the queue has room.
module lcw_front
    import lcw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_in_req i_req,
    output t_job    o_job
);

    typedef enum logic [14:0] {
        PH_OPCODE  = 15'b000000000000001,
        PH_REL_LO  = 15'b000000000000010,
        PH_LITERAL = 15'b000000000000100,
        PH_ABS_LO  = 15'b000000000001000,
        PH_ABS_HI  = 15'b000000000010000,
        PH_FILL_C0 = 15'b000000000100000,
        PH_FILL_C1 = 15'b000000001000000,
        PH_FILL_V  = 15'b000000010000000,
        PH_LONG_C0 = 15'b000000100000000,
        PH_LONG_C1 = 15'b000001000000000,
        PH_LONG_P0 = 15'b000010000000000,
        PH_LONG_P1 = 15'b000100000000000,
        PH_COPY    = 15'b001000000000000,
        PH_FILL    = 15'b010000000000000,
        PH_DONE    = 15'b100000000000000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_wp, n_wp;
    logic [15:0]        r_src, n_src;
    logic [15:0]        r_rem, n_rem;
    logic [7:0]         r_held, n_held;
    logic [7:0]         r_low, n_low;
    logic [7:0]         r_fill, n_fill;

    logic               start;
    logic [POS_W-1:0]   st_src;
    logic [15:0]        st_cnt;
    logic [11:0]        offset;
    logic [7:0]         b;

    always_comb begin
        n_phase = r_phase;
        n_wp    = r_wp;
        n_src   = r_src;
        n_rem   = r_rem;
        n_held  = r_held;
        n_low   = r_low;
        n_fill  = r_fill;
        start   = 1'b0;
        st_src  = '0;
        st_cnt  = '0;
        b       = i_req.data_byte;
        offset  = 12'({r_held & OP_RELHI, b});
        o_job   = '0;
        o_job.status  = ST_ABSORBED;
        o_job.pos     = r_wp;
        o_job.rd_addr = r_src;

        if (r_phase == PH_DONE) begin
            o_job.status = ST_END;
        end else if (r_phase == PH_COPY || r_phase == PH_FILL) begin
            if (!i_req.command) begin
                o_job.status = ST_WRONG;
            end else if (r_wp >= OUT_SIZE_POS) begin
                n_rem   = '0;
                n_phase = PH_OPCODE;
                o_job.status = ST_BAD;
            end else begin
                o_job.status   = ST_BYTE;
                o_job.wr       = 1'b1;
                o_job.is_copy  = (r_phase == PH_COPY);
                o_job.byte_val = r_fill;
                if (r_phase == PH_COPY) begin
                    n_src = r_src + 16'd1;
                end
                n_wp  = r_wp + POS_W'(1);
                n_rem = r_rem - 16'd1;
                if (n_rem == 16'd0) begin
                    n_phase = PH_OPCODE;
                end
            end
        end else if (i_req.command) begin
            o_job.status = ST_WRONG;
        end else begin
            case (r_phase)
                PH_REL_LO: begin
                    if (POS_W'(offset) > r_wp) begin
                        n_phase = PH_OPCODE;
                        n_rem   = '0;
                        o_job.status = ST_BAD;
                    end else begin
                        start  = 1'b1;
                        st_src = r_wp - POS_W'(offset);
                        st_cnt = 16'(r_held[6:4]) + 16'd3;
                    end
                end
                PH_LITERAL: begin
                    n_rem = r_rem - 16'd1;
                    if (n_rem == 16'd0) begin
                        n_phase = PH_OPCODE;
                    end
                    if (r_wp >= OUT_SIZE_POS) begin
                        o_job.status = ST_BAD;
                    end else begin
                        o_job.status   = ST_BYTE;
                        o_job.wr       = 1'b1;
                        o_job.byte_val = b;
                        n_wp = r_wp + POS_W'(1);
                    end
                end
                PH_ABS_LO: begin
                    n_low   = b;
                    n_phase = PH_ABS_HI;
                end
                PH_ABS_HI, PH_LONG_P1: begin
                    start  = 1'b1;
                    st_src = POS_W'({b, r_low});
                    st_cnt = r_rem;
                end
                PH_FILL_C0: begin
                    n_low   = b;
                    n_phase = PH_FILL_C1;
                end
                PH_FILL_C1: begin
                    n_rem   = {b, r_low};
                    n_phase = PH_FILL_V;
                end
                PH_FILL_V: begin
                    n_fill  = b;
                    n_phase = (r_rem != 16'd0) ? PH_FILL : PH_OPCODE;
                end
                PH_LONG_C0: begin
                    n_low   = b;
                    n_phase = PH_LONG_C1;
                end
                PH_LONG_C1: begin
                    n_rem   = {b, r_low};
                    n_phase = PH_LONG_P0;
                end
                PH_LONG_P0: begin
                    n_low   = b;
                    n_phase = PH_LONG_P1;
                end
                default: begin
                    n_held = b;
                    if ((b & OP_TOP) == 8'h00) begin
                        n_phase = PH_REL_LO;
                    end else if ((b & OP_LIT) == 8'h00) begin
                        n_rem = 16'(b & OP_CMASK);
                        if ((b & OP_CMASK) == 8'h00) begin
                            n_phase = PH_DONE;
                            o_job.status = ST_END;
                        end else begin
                            n_phase = PH_LITERAL;
                        end
                    end else if (b[5:0] < OP_FILL) begin
                        n_rem   = 16'(b & OP_CMASK) + 16'd3;
                        n_phase = PH_ABS_LO;
                    end else if (b[5:0] == OP_FILL) begin
                        n_phase = PH_FILL_C0;
                    end else begin
                        n_phase = PH_LONG_C0;
                    end
                end
            endcase

            if (start) begin
                n_phase = PH_OPCODE;
                n_rem   = '0;
                if (st_cnt == 16'd0) begin
                    o_job.status = ST_ABSORBED;
                end else if (st_src >= r_wp) begin
                    o_job.status = ST_BAD;
                end else begin
                    n_src   = st_src[15:0];
                    n_rem   = st_cnt;
                    n_phase = PH_COPY;
                end
            end
        end

        o_job.expanding = (n_phase == PH_COPY) || (n_phase == PH_FILL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPCODE;
            r_wp    <= '0;
            r_src   <= '0;
            r_rem   <= '0;
            r_held  <= '0;
            r_low   <= '0;
            r_fill  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_wp    <= n_wp;
            r_src   <= n_src;
            r_rem   <= n_rem;
            r_held  <= n_held;
            r_low   <= n_low;
            r_fill  <= n_fill;
        end
    end

endmodule

// ----- rtl/lcw_queue.sv -----
// Short request queue between the front and the back.
module lcw_queue
    import lcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

endmodule

// ----- rtl/lcw_back.sv -----
// Back: history memory, copy read with forwarding, and the output register.
module lcw_back
    import lcw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_job     i_q_job,
    output logic     o_pop,
    input  logic     i_out_stall,
    output logic     o_out_valid,
    output t_out_rsp o_out_rsp
);

    logic [7:0] r_hist [2**HIST_AW];

    logic       r_b_valid;
    t_job       r_b;
    logic [7:0] r_mem_q;
    logic       r_fwd_hit;
    logic [7:0] r_fwd_val;
    logic       r_o_valid;
    t_out_rsp   r_o;

    logic       out_free;
    logic       b_go;
    logic [7:0] b_val;

    assign out_free = !r_o_valid || !i_out_stall;
    assign b_go     = r_b_valid && out_free;
    assign o_pop    = i_q_valid && (!r_b_valid || b_go);
    assign b_val    = !r_b.is_copy ? r_b.byte_val : (r_fwd_hit ? r_fwd_val : r_mem_q);

    always_ff @(posedge i_clk) begin
        if (b_go && r_b.wr) begin
            r_hist[r_b.pos[HIST_AW-1:0]] <= b_val;
        end
        if (o_pop) begin
            r_mem_q <= r_hist[i_q_job.rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b       <= i_q_job;
            r_fwd_hit <= b_go && r_b.wr && (r_b.pos[HIST_AW-1:0] == i_q_job.rd_addr);
            r_fwd_val <= b_val;
        end
        if (b_go) begin
            r_o.status       <= r_b.status;
            r_o.out_byte     <= (r_b.status == ST_BYTE) ? b_val : 8'h00;
            r_o.out_position <= r_b.pos;
            r_o.expanding    <= r_b.expanding;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
            if (b_go) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_rsp   = r_o;

endmodule

// ----- test/lcw_format80_decompressor_test.sv -----
// Self-checking testbench for the Format80 (LCW) decompressor.
`timescale 1ns / 100ps

module lcw_format80_decompressor_test;
    import lcw_pkg::*;

    // Decoder phases of the prediction, one per step of the command grammar.
    typedef enum logic [3:0] {
        PH_OPCODE, PH_REL_LO, PH_LITERAL, PH_ABS_LO, PH_ABS_HI,
        PH_FILL_C0, PH_FILL_C1, PH_FILL_V, PH_LONG_C0, PH_LONG_C1,
        PH_LONG_P0, PH_LONG_P1, PH_COPY, PH_FILL, PH_DONE
    } t_phase;

    localparam logic CMD_SUPPLY  = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;
    localparam int   CYCLE_LIMIT = 2000000;
    localparam int   DRAIN_WAIT  = 20;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_stall;
    t_out_rsp o_out_rsp;

    lcw_format80_decompressor u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Decoder state mirrored by the predictor.
    logic [7:0]       img [0:65535];
    logic [16:0]      wr_pos;
    logic [15:0]      src_pos;
    logic [15:0]      left;
    t_phase           phase;
    logic [7:0]       op_held;
    logic [7:0]       lo_half;
    logic [7:0]       fill_byte;

    t_out_rsp decoded_q[$];       // responses still owed by the block
    int       errors;
    int       cycles;
    int       n_sent;
    int       n_seen;
    int       n_bytes_out;
    int       n_bad;
    int       idle_pct;
    int       stall_pct;
    bit       hold_off;

    task automatic report(input string what, input t_out_rsp got, input t_out_rsp want);
        errors++;
        $display({"MISMATCH %s at response %0d: got st=%0d b=%02h p=%0d x=%0d,",
                  " want st=%0d b=%02h p=%0d x=%0d"},
            what, n_seen, got.status, got.out_byte, got.out_position, got.expanding,
            want.status, want.out_byte, want.out_position, want.expanding);
    endtask

    function automatic t_out_rsp mk(input logic [2:0] st, input logic [7:0] b,
                                    input logic [16:0] p, input logic x);
        t_out_rsp r;
        r.status = st;
        r.out_byte = b;
        r.out_position = p;
        r.expanding = x;
        return r;
    endfunction

    function automatic logic [2:0] begin_copy(input logic [16:0] from, input logic [15:0] n);
        phase = PH_OPCODE;
        left = '0;
        if (n == 0) return ST_ABSORBED;
        if (from >= wr_pos) return ST_BAD;
        src_pos = from[15:0];
        left = n;
        phase = PH_COPY;
        return ST_ABSORBED;
    endfunction

    // Advances the mirrored decoder by one request and returns its response.
    function automatic t_out_rsp decode_step(input t_in_req rq);
        logic [2:0]  st;
        logic [7:0]  v;
        logic [16:0] p;
        logic [11:0] offs;
        st = ST_ABSORBED;
        if (phase == PH_DONE) return mk(ST_END, 8'h00, wr_pos, 1'b0);
        if (phase == PH_COPY || phase == PH_FILL) begin
            if (rq.command == CMD_SUPPLY) return mk(ST_WRONG, 8'h00, wr_pos, 1'b1);
            if (wr_pos >= OUT_SIZE_POS) begin
                left = '0;
                phase = PH_OPCODE;
                return mk(ST_BAD, 8'h00, wr_pos, 1'b0);
            end
            if (phase == PH_COPY) begin
                v = img[src_pos];
                src_pos++;
            end else begin
                v = fill_byte;
            end
            p = wr_pos;
            img[wr_pos[15:0]] = v;
            wr_pos++;
            left--;
            if (left == 0) phase = PH_OPCODE;
            return mk(ST_BYTE, v, p, left != 0);
        end
        if (rq.command != CMD_SUPPLY) return mk(ST_WRONG, 8'h00, wr_pos, 1'b0);
        case (phase)
            PH_REL_LO: begin
                offs = {op_held[3:0], rq.data_byte};
                if (offs > wr_pos) begin
                    phase = PH_OPCODE;
                    left = '0;
                    st = ST_BAD;
                end else begin
                    st = begin_copy(wr_pos - offs, 16'(op_held[6:4]) + 16'd3);
                end
            end
            PH_LITERAL: begin
                p = wr_pos;
                left--;
                if (left == 0) phase = PH_OPCODE;
                if (p >= OUT_SIZE_POS) return mk(ST_BAD, 8'h00, p, 1'b0);
                img[wr_pos[15:0]] = rq.data_byte;
                wr_pos++;
                return mk(ST_BYTE, rq.data_byte, p, 1'b0);
            end
            PH_ABS_LO: begin lo_half = rq.data_byte; phase = PH_ABS_HI; end
            PH_ABS_HI: st = begin_copy({1'b0, rq.data_byte, lo_half}, left);
            PH_FILL_C0: begin lo_half = rq.data_byte; phase = PH_FILL_C1; end
            PH_FILL_C1: begin left = {rq.data_byte, lo_half}; phase = PH_FILL_V; end
            PH_FILL_V: begin
                fill_byte = rq.data_byte;
                phase = (left != 0) ? PH_FILL : PH_OPCODE;
            end
            PH_LONG_C0: begin lo_half = rq.data_byte; phase = PH_LONG_C1; end
            PH_LONG_C1: begin left = {rq.data_byte, lo_half}; phase = PH_LONG_P0; end
            PH_LONG_P0: begin lo_half = rq.data_byte; phase = PH_LONG_P1; end
            PH_LONG_P1: st = begin_copy({1'b0, rq.data_byte, lo_half}, left);
            default: begin
                op_held = rq.data_byte;
                if ((rq.data_byte & OP_TOP) == 0) begin
                    phase = PH_REL_LO;
                end else if ((rq.data_byte & OP_LIT) == 0) begin
                    left = 16'(rq.data_byte & OP_CMASK);
                    if (left == 0) begin
                        phase = PH_DONE;
                        return mk(ST_END, 8'h00, wr_pos, 1'b0);
                    end
                    phase = PH_LITERAL;
                end else if (rq.data_byte[5:0] < OP_FILL) begin
                    left = 16'(rq.data_byte[5:0]) + 16'd3;
                    phase = PH_ABS_LO;
                end else if (rq.data_byte[5:0] == OP_FILL) begin
                    phase = PH_FILL_C0;
                end else begin
                    phase = PH_LONG_C0;
                end
            end
        endcase
        return mk(st, 8'h00, wr_pos, phase == PH_COPY || phase == PH_FILL);
    endfunction

    // Sender: holds the request until it is taken, then queues its prediction.
    // Valid stays up into the next request unless the sender idles first.
    task automatic send(input logic cmd, input logic [7:0] b);
        t_out_rsp want;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= '{command: cmd, data_byte: b};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = decode_step('{command: cmd, data_byte: b});
        decoded_q.push_back(want);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic supply(input logic [7:0] b);
        send(CMD_SUPPLY, b);
    endtask

    // Drains a pending copy or fill, sometimes poking a stray byte in first.
    task automatic drain_expansion();
        while (phase == PH_COPY || phase == PH_FILL) begin
            if ($urandom_range(40) == 0) supply(8'($urandom));
            send(CMD_ADVANCE, 8'($urandom));
        end
    endtask

    // Directed rows: command, byte, and a typed answer where it is obvious.
    typedef struct {
        logic       cmd;
        logic [7:0] b;
        bit         typed;
        t_out_rsp   ans;
    } t_row;

    t_row rows[$];
    t_out_rsp typed_q[$];
    bit       typed_flag_q[$];

    task automatic add_row(input logic cmd, input logic [7:0] b, input int typed,
                           input int st, input int ob, input int p, input int x);
        t_row r;
        r.cmd = cmd;
        r.b = b;
        r.typed = (typed != 0);
        r.ans = mk(3'(st), 8'(ob), 17'(p), 1'(x));
        rows.push_back(r);
    endtask

    task automatic reset_model();
        wr_pos = '0;
        src_pos = '0;
        left = '0;
        phase = PH_OPCODE;
        op_held = '0;
        lo_half = '0;
        fill_byte = '0;
    endtask

    // Random well-formed command with random content, with some noise.
    task automatic random_command();
        int kind;
        int n;
        logic [15:0] from;
        kind = $urandom_range(99);
        if (wr_pos == 0 || kind < 25) begin
            n = $urandom_range(1, 63);
            if ($urandom_range(9) == 0) n = 63;
            supply(8'h80 | 8'(n));
            repeat (n) supply(8'($urandom));
        end else if (kind < 45) begin
            n = (wr_pos > 4095) ? 4095 : int'(wr_pos);
            n = $urandom_range(1, n);
            if ($urandom_range(15) == 0) n = 0;
            if ($urandom_range(15) == 0) n = int'(wr_pos) + 1;
            supply({1'b0, 3'($urandom), 4'(n >> 8)});
            supply(8'(n));
        end else if (kind < 60) begin
            n = $urandom_range(0, 8'h3d);
            from = 16'($urandom_range(0, int'(wr_pos) - 1));
            if ($urandom_range(15) == 0) from = 16'($urandom);
            supply(8'hc0 | 8'(n));
            supply(from[7:0]);
            supply(from[15:8]);
        end else if (kind < 75) begin
            n = $urandom_range(0, 40);
            if ($urandom_range(20) == 0) n = $urandom_range(0, 600);
            supply(8'hfe);
            supply(8'(n));
            supply(8'(n >> 8));
            supply(8'($urandom));
        end else if (kind < 90) begin
            n = $urandom_range(0, 40);
            from = 16'($urandom_range(0, int'(wr_pos) - 1));
            if ($urandom_range(15) == 0) from = 16'($urandom);
            supply(8'hff);
            supply(8'(n));
            supply(8'(n >> 8));
            supply(from[7:0]);
            supply(from[15:8]);
        end else begin
            // noise: a stray advance
            send(CMD_ADVANCE, 8'($urandom));
        end
        drain_expansion();
    endtask

    // Receiver: random stalls plus one long hold-off.
    initial begin
        int k;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                for (k = 0; k < 200; k++) @(negedge i_clk);
                hold_off = 1'b0;
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Checker: compares each accepted response with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decoded_q.size() == 0) begin
                report("unexpected response", o_out_rsp,
                       mk(ST_ABSORBED, 8'h00, 17'd0, 1'b0));
            end else begin
                want = decoded_q.pop_front();
                if (typed_flag_q.size() > 0) begin
                    if (typed_flag_q.pop_front() && typed_q[0] != want)
                        report("typed row vs predictor", want, typed_q[0]);
                    void'(typed_q.pop_front());
                end
                if (o_out_rsp.status != want.status) report("status", o_out_rsp, want);
                else if (o_out_rsp.out_byte != want.out_byte) report("byte", o_out_rsp, want);
                else if (o_out_rsp.out_position != want.out_position)
                    report("position", o_out_rsp, want);
                else if (o_out_rsp.expanding != want.expanding)
                    report("expanding", o_out_rsp, want);
                if (o_out_rsp.status == ST_BYTE) n_bytes_out++;
                if (o_out_rsp.status == ST_BAD) n_bad++;
                n_seen++;
            end
        end
    end

    // Watchdog.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int i;
        int pass;
        errors = 0;
        n_sent = 0;
        n_seen = 0;
        n_bytes_out = 0;
        n_bad = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_req = '0;
        reset_model();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: a wrong command after reset, every opcode kind, bad references,
        // and zero counts.
        add_row(CMD_ADVANCE, 8'h00, 1, ST_WRONG, 0, 0, 0);     // advance with nothing pending
        add_row(CMD_SUPPLY,  8'h00, 1, ST_ABSORBED, 0, 0, 0);  // relative copy, offset 0 ...
        add_row(CMD_SUPPLY,  8'h00, 1, ST_BAD, 0, 0, 0);       // ... is a bad reference
        add_row(CMD_SUPPLY,  8'h82, 1, ST_ABSORBED, 0, 0, 0);  // two literals
        add_row(CMD_SUPPLY,  8'hff, 1, ST_BYTE, 8'hff, 0, 0);
        add_row(CMD_SUPPLY,  8'h00, 1, ST_BYTE, 8'h00, 1, 0);
        add_row(CMD_SUPPLY,  8'h00, 0, 0, 0, 0, 0);            // relative copy 3 from -1
        add_row(CMD_SUPPLY,  8'h01, 0, 0, 0, 0, 0);
        add_row(CMD_SUPPLY,  8'h55, 1, ST_WRONG, 0, 2, 1);     // byte during a copy
        add_row(CMD_ADVANCE, 8'h00, 0, 0, 0, 0, 0);
        add_row(CMD_ADVANCE, 8'hff, 0, 0, 0, 0, 0);
        add_row(CMD_ADVANCE, 8'h00, 0, 0, 0, 0, 0);
        add_row(CMD_SUPPLY,  8'hfe, 0, 0, 0, 0, 0);            // fill with count 0
        add_row(CMD_SUPPLY,  8'h00, 0, 0, 0, 0, 0);
        add_row(CMD_SUPPLY,  8'h00, 0, 0, 0, 0, 0);
        add_row(CMD_SUPPLY,  8'haa, 1, ST_ABSORBED, 0, 5, 0);
        add_row(CMD_SUPPLY,  8'hff, 0, 0, 0, 0, 0);            // long copy, source ahead
        add_row(CMD_SUPPLY,  8'h02, 0, 0, 0, 0, 0);
        add_row(CMD_SUPPLY,  8'h00, 0, 0, 0, 0, 0);
        add_row(CMD_SUPPLY,  8'hff, 0, 0, 0, 0, 0);
        add_row(CMD_SUPPLY,  8'hff, 1, ST_BAD, 0, 5, 0);
        add_row(CMD_SUPPLY,  8'hfd, 0, 0, 0, 0, 0);            // absolute copy 64 from 0
        add_row(CMD_SUPPLY,  8'h00, 0, 0, 0, 0, 0);
        add_row(CMD_SUPPLY,  8'h00, 0, 0, 0, 0, 0);
        foreach (rows[j]) begin
            typed_flag_q.push_back(rows[j].typed);
            typed_q.push_back(rows[j].ans);
            send(rows[j].cmd, rows[j].b);
        end
        drain_expansion();

        // Random part in idling phases; pressure during the first one.
        for (pass = 0; pass < 4; pass++) begin
            case (pass)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 63; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            if (pass == 0) hold_off = 1'b1;
            i = n_sent;
            while (n_sent - i < 270) random_command();
        end

        // Short literal run, then the end mark and requests after it.
        idle_pct = 0;
        stall_pct = 10;
        supply(8'h83);
        repeat (3) supply(8'($urandom));
        supply(8'h80);                         // end mark
        send(CMD_ADVANCE, 8'h00);
        supply(8'h12);
        i_in_valid <= 1'b0;

        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Covered %0d requests: %0d image bytes out, %0d bad references,",
                 n_sent, n_bytes_out, n_bad);
        $display("all opcode kinds, end mark, and four idle/stall mixes with a long hold-off.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lcw_pkg.sv
rtl/lcw_front.sv
rtl/lcw_queue.sv
rtl/lcw_back.sv
rtl/lcw_format80_decompressor.sv
test/lcw_format80_decompressor_test.sv
